FILE: rtl/core/radsimp_pkg.sv
// ----------------------------------------------------------------------------
// radsimp_pkg
// Control word layout and microprogram for the radical simplifier sequencer.
// ----------------------------------------------------------------------------
package radsimp_pkg;

	// Step counter width: the program has exactly 1 << STEP_W steps
	localparam int STEP_W = 3;

	typedef logic [STEP_W-1:0] step_t;

	// Datapath operation selected by the current step
	typedef enum logic [3:0] {
		OP_LOAD,       // take a request from the input channel
		OP_SQUARE,     // square the trial factor
		OP_DIV_START,  // load the divider with radicand and square
		OP_DIV_STEP,   // one restoring division bit
		OP_CHECK,      // exact division: keep quotient, else next factor
		OP_MULK,       // fold the trial factor into the root
		OP_PROD,       // coefficient times root
		OP_EMIT        // write the result register
	} op_t;

	// Jump condition: jump to the target when true, else advance one step
	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_NO_INPUT,  // no request offered
		JMP_SQ_GT,     // square exceeds remaining radicand
		JMP_DIV_BUSY,  // division bits still to go
		JMP_REM_NZ,    // division left a remainder
		JMP_OUT_FULL   // result register still held
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// Step addresses
	localparam step_t ST_LOAD   = 3'd0;
	localparam step_t ST_SQUARE = 3'd1;
	localparam step_t ST_TEST   = 3'd2;
	localparam step_t ST_DIV    = 3'd3;
	localparam step_t ST_CHECK  = 3'd4;
	localparam step_t ST_MULK   = 3'd5;
	localparam step_t ST_FINAL  = 3'd6;
	localparam step_t ST_EMIT   = 3'd7;

	// Microprogram ROM. Advancing past the emit step wraps to the load step.
	function automatic ctrl_word_t ucode_rom(input step_t addr);
		ctrl_word_t w;
		case (addr)
			ST_LOAD:   w = '{op: OP_LOAD,      cond: JMP_NO_INPUT, target: ST_LOAD};
			ST_SQUARE: w = '{op: OP_SQUARE,    cond: JMP_NEVER,    target: ST_LOAD};
			ST_TEST:   w = '{op: OP_DIV_START, cond: JMP_SQ_GT,    target: ST_FINAL};
			ST_DIV:    w = '{op: OP_DIV_STEP,  cond: JMP_DIV_BUSY, target: ST_DIV};
			ST_CHECK:  w = '{op: OP_CHECK,     cond: JMP_REM_NZ,   target: ST_SQUARE};
			ST_MULK:   w = '{op: OP_MULK,      cond: JMP_ALWAYS,   target: ST_SQUARE};
			ST_FINAL:  w = '{op: OP_PROD,      cond: JMP_NEVER,    target: ST_LOAD};
			ST_EMIT:   w = '{op: OP_EMIT,      cond: JMP_OUT_FULL, target: ST_EMIT};
			default:   w = '{op: OP_LOAD,      cond: JMP_NO_INPUT, target: ST_LOAD};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/radical_simplifier_top.sv
// ----------------------------------------------------------------------------
// radical_simplifier_top
// Simplifies c*sqrt(r) to (c*k)*sqrt(r/k^2) with k^2 the largest square
// dividing r; the coefficient saturates and flags overflow.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                  handshake
//  s_axis   in   tdata: coef_in, radicand_in              tvalid/tready
//  m_axis   out  tdata: coef_out, radicand_out            tvalid/tready
//                tuser: coef_overflow
//
//  One request at a time. Trial factors p = 2, 3, ... are tried while p*p does
//  not exceed the remaining radicand; each trial squares p and runs the
//  one-bit-per-cycle restoring divider, then checks the remainder. Each square
//  factor removed adds a repeat trial of the same p and a step to fold p into
//  the root. The worst case is a prime near the top of the range.
//  The result register frees the input side: a new request is taken while a
//  result waits. Reset clears the sequencer and the result valid.
//
module radical_simplifier_top #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// tdata: coef_in [W-1:0], radicand_in [2W-1:W], zero pad
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// tdata: coef_out [W-1:0], radicand_out [2W-1:W], zero pad
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
	// tuser: coef_overflow
	output logic                                   m_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready
);
	import radsimp_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int BUSW = ((2*W+7)/8)*8;
	localparam int HW   = (W+1)/2 + 1;   // trial factor and root width
	localparam int HW2  = 2*HW;          // square width
	localparam int PW   = W + HW;        // coefficient product width
	localparam int CW   = $clog2(W+1);   // division bit counter width

	step_t         step_q;
	ctrl_word_t    ctrl;
	logic          jump;
	logic          in_fire;
	logic          out_free;

	logic [W-1:0]   coef_q;
	logic [W-1:0]   rem_q;
	logic [HW-1:0]  p_q;
	logic [HW-1:0]  k_q;
	logic [HW2-1:0] sq_q;
	logic [PW-1:0]  prod_q;

	logic [W-1:0]   div_r_q;
	logic [W-1:0]   div_q_q;
	logic [W-1:0]   divisor_q;
	logic [CW-1:0]  div_cnt_q;

	logic [W:0]     div_trial;
	logic [W:0]     div_diff;
	logic           sq_gt;
	logic [HW2-1:0] sq_next;
	logic [HW2-1:0] kp_next;
	logic [PW-1:0]  prod_next;

	logic [W-1:0]   coef_out_q;
	logic [W-1:0]   rad_out_q;
	logic           ovf_out_q;
	logic           out_valid_q;
	logic [W-1:0]   coef_sat;
	logic           prod_ovf;

	// Fetch the control word of the current step
	assign ctrl = ucode_rom(step_q);

	assign s_axis_tready = (ctrl.op == OP_LOAD);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Datapath arithmetic
	assign sq_next   = HW2'(p_q) * HW2'(p_q);
	assign kp_next   = HW2'(k_q) * HW2'(p_q);
	assign prod_next = PW'(coef_q) * PW'(k_q);
	assign sq_gt     = sq_q > HW2'(rem_q);
	assign div_trial = {div_r_q, div_q_q[W-1]};
	assign div_diff  = div_trial - {1'b0, divisor_q};

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			JMP_NEVER:    jump = 1'b0;
			JMP_ALWAYS:   jump = 1'b1;
			JMP_NO_INPUT: jump = !s_axis_tvalid;
			JMP_SQ_GT:    jump = sq_gt;
			JMP_DIV_BUSY: jump = (div_cnt_q != CW'(1));
			JMP_REM_NZ:   jump = (div_r_q != '0);
			JMP_OUT_FULL: jump = !out_free;
			default:      jump = 1'b0;
		endcase
	end

	// Advance the step counter or take the jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			step_q <= jump ? ctrl.target : step_q + step_t'(1);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_fire) begin
					coef_q <= s_axis_tdata[W-1:0];
					rem_q  <= s_axis_tdata[2*W-1:W];
					k_q    <= HW'(1);
					p_q    <= HW'(2);
				end
			end
			OP_SQUARE: begin
				sq_q <= sq_next;
			end
			OP_DIV_START: begin
				div_r_q   <= '0;
				div_q_q   <= rem_q;
				divisor_q <= sq_q[W-1:0];
				div_cnt_q <= CW'(W);
			end
			OP_DIV_STEP: begin
				// Restoring step: keep the difference when it does not go negative
				if (!div_diff[W]) begin
					div_r_q <= div_diff[W-1:0];
				end else begin
					div_r_q <= div_trial[W-1:0];
				end
				div_q_q   <= {div_q_q[W-2:0], !div_diff[W]};
				div_cnt_q <= div_cnt_q - CW'(1);
			end
			OP_CHECK: begin
				// Exact: drop the square factor and retry the same p
				if (div_r_q == '0) begin
					rem_q <= div_q_q;
				end else begin
					p_q <= p_q + HW'(1);
				end
			end
			OP_MULK: begin
				k_q <= kp_next[HW-1:0];
			end
			OP_PROD: begin
				prod_q <= prod_next;
			end
			default: begin
			end
		endcase
	end

	// Saturate the coefficient product
	assign prod_ovf = (prod_q[PW-1:W] != '0);
	assign coef_sat = prod_ovf ? '1 : prod_q[W-1:0];

	// Result register payload; a zero radicand gives 0 * sqrt(1)
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT && out_free) begin
			if (rem_q == '0) begin
				coef_out_q <= '0;
				rad_out_q  <= W'(1);
				ovf_out_q  <= 1'b0;
			end else begin
				coef_out_q <= coef_sat;
				rad_out_q  <= rem_q;
				ovf_out_q  <= prod_ovf;
			end
		end
	end

	// Result valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = ovf_out_q;
	assign m_axis_tdata  = BUSW'({rad_out_q, coef_out_q});

endmodule

FILE: tb/radical_simplifier_checker.sv
// ----------------------------------------------------------------------------
// radical_simplifier_checker
// Watches both stream channels of the radical simplifier. It works out the
// simplified radical for every accepted request. Each returned result is
// compared field by field, in order, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module radical_simplifier_checker #(
	parameter int DATA_WIDTH = 16,
	parameter int TDATA_W    = ((2*DATA_WIDTH+7)/8)*8
) (
	input  logic               clk,
	input  logic               arst_n,
	// tdata: coef_in, radicand_in, zero pad
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	// tdata: coef_out, radicand_out, zero pad
	input  logic [TDATA_W-1:0] m_axis_tdata,
	// tuser: coef_overflow
	input  logic               m_axis_tuser,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output int                 fail_count,
	output int                 results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Simplified radical, plus the request it came from for reporting
	typedef struct {
		word_t coef;
		word_t radicand;
		logic  overflow;
		word_t src_coef;
		word_t src_radicand;
	} radical_t;

	radical_t simplified_q[$];
	int       reported;

	// Pull the largest square factor k*k out of the radicand, scale the
	// coefficient by k and saturate it at the all-ones word
	function automatic radical_t simplify_radical(input word_t coef, input word_t radicand);
		longint unsigned r;
		longint unsigned k;
		longint unsigned root;
		longint unsigned prod;
		longint unsigned word_max;
		radical_t        res;
		word_max         = (64'd1 << DATA_WIDTH) - 1;
		r                = radicand;
		res.src_coef     = coef;
		res.src_radicand = radicand;
		if (r == 0) begin
			res.coef     = '0;
			res.radicand = word_t'(1);
			res.overflow = 1'b0;
			return res;
		end
		root = 1;
		for (k = 2; k * k <= r; k++) begin
			if (r % (k * k) == 0)
				root = k;
		end
		prod         = longint'(coef) * root;
		res.overflow = (prod > word_max);
		res.coef     = res.overflow ? word_max[DATA_WIDTH-1:0] : prod[DATA_WIDTH-1:0];
		res.radicand = word_t'(r / (root * root));
		return res;
	endfunction

	task automatic log_mismatch(input string what, input radical_t want,
			input longint unsigned want_v, input longint unsigned got_v);
		fail_count++;
		if (reported < 10) begin
			reported++;
			$display("%0t ns: %s mismatch for request coef %0d radicand %0d: expected %0d, got %0d",
				$time, what, want.src_coef, want.src_radicand, want_v, got_v);
		end
	endtask

	// Retire results first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin
		radical_t want;
		word_t    got_coef;
		word_t    got_radicand;
		if (!arst_n) begin
			simplified_q.delete();
			fail_count  = 0;
			results_due = 0;
			reported    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_coef     = m_axis_tdata[DATA_WIDTH-1:0];
				got_radicand = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
				if (simplified_q.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("%0t ns: result with no request outstanding: coef %0d radicand %0d overflow %0b",
							$time, got_coef, got_radicand, m_axis_tuser);
					end
				end else begin
					want = simplified_q.pop_front();
					if (got_coef !== want.coef)
						log_mismatch("coef_out", want, 64'(want.coef), 64'(got_coef));
					if (got_radicand !== want.radicand)
						log_mismatch("radicand_out", want, 64'(want.radicand),
							64'(got_radicand));
					if (m_axis_tuser !== want.overflow)
						log_mismatch("coef_overflow", want, 64'(want.overflow),
							64'(m_axis_tuser));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				simplified_q.push_back(simplify_radical(s_axis_tdata[DATA_WIDTH-1:0],
					s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			results_due = simplified_q.size();
		end
	end

endmodule

FILE: tb/radical_simplifier_top_tb.sv
// ----------------------------------------------------------------------------
// radical_simplifier_top_tb
// Drives requests into the radical simplifier: first a directed set of edge
// cases, then a random mix biased towards radicands that are fast to
// simplify. Requests go out in bursts with gaps and results are taken with
// changing stall patterns. Checking is left to the checker module.
// ----------------------------------------------------------------------------
module radical_simplifier_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_WIDTH      = 16;
	localparam int TDATA_W         = ((2*DATA_WIDTH+7)/8)*8;
	localparam int WORD_MAX        = (1 << DATA_WIDTH) - 1;
	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_REQUESTS = 1830;
	// Worst request is a large prime
	localparam int DRAIN_CYCLES    = 5000;
	localparam int STALL_LIMIT     = 50000;
	localparam int DIRECTED_COUNT  = 24;

	// Directed requests: zero and unit radicands, zero and full coefficients,
	// exact and just-over saturation, perfect squares, primes and powers of two
	localparam logic [DATA_WIDTH-1:0] DIRECTED_COEF [DIRECTED_COUNT] = '{
		16'd0, 16'd5, 16'd65535, 16'd0, 16'd65535, 16'd7, 16'd0, 16'd3,
		16'd1, 16'd2, 16'd65535, 16'd1, 16'd65535, 16'd257, 16'd258, 16'd1,
		16'd100, 16'd1, 16'd65535, 16'd32767, 16'd32768, 16'd12345, 16'd43690, 16'd21845
	};
	localparam logic [DATA_WIDTH-1:0] DIRECTED_RADICAND [DIRECTED_COUNT] = '{
		16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd72, 16'd12,
		16'd4, 16'd65535, 16'd65535, 16'd65025, 16'd65025, 16'd65025, 16'd65025, 16'd65521,
		16'd49152, 16'd32768, 16'd4, 16'd4, 16'd4, 16'd99, 16'd21845, 16'd43690
	};

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE
	} ready_mode_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;

	int                 fail_count;
	int                 results_due;
	int                 burst_left    = 0;
	int                 idle_cycles   = 0;
	ready_mode_t        ready_mode    = READY_ALWAYS;
	int                 mode_left     = 0;

	radical_simplifier_top #(
		.DATA_WIDTH(DATA_WIDTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready)
	);

	radical_simplifier_checker #(
		.DATA_WIDTH(DATA_WIDTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	initial begin
		forever #(CLK_PERIOD/2) clk = ~clk;
	end

	// Open a new burst after a random gap, then hold the request until taken
	task automatic send_request(input logic [DATA_WIDTH-1:0] coef,
			input logic [DATA_WIDTH-1:0] radicand);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 19))
				0:       gap = $urandom_range(100, 800);
				1, 2, 3: gap = $urandom_range(4, 60);
				default: gap = $urandom_range(0, 3);
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
		end
		burst_left--;
		s_axis_tdata  <= TDATA_W'({radicand, coef});
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stall the result side: switch between always ready, coin toss and
	// mostly stalled stretches of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_mode    <= READY_ALWAYS;
			mode_left     <= 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 2));
				mode_left  <= $urandom_range(20, 600);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				READY_ALWAYS: m_axis_tready <= 1'b1;
				READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				default:      m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Give up when no request or result has moved for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned                pick;
		int unsigned                root;
		int unsigned                max_m;
		int unsigned                boundary;
		logic [DATA_WIDTH-1:0]      coef;
		logic [DATA_WIDTH-1:0]      radicand;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_request(DIRECTED_COEF[i], DIRECTED_RADICAND[i]);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			// Radicand: mostly small or built from a known square factor,
			// since each trial factor costs a full division
			pick = $urandom_range(0, 99);
			root = 1;
			if (pick < 40) begin
				radicand = DATA_WIDTH'($urandom_range(0, 1023));
			end else if (pick < 74) begin
				root     = $urandom_range(0, 2) == 0 ? $urandom_range(1, 255) : $urandom_range(1, 40);
				max_m    = WORD_MAX / (root * root);
				radicand = DATA_WIDTH'(root * root *
					$urandom_range(1, max_m < 64 ? max_m : 64));
			end else if (pick < 90) begin
				root     = $urandom_range(0, 255);
				radicand = DATA_WIDTH'(root * root);
				if (root == 0)
					root = 1;
			end else begin
				radicand = DATA_WIDTH'($urandom_range(0, WORD_MAX));
			end

			// Coefficient: full range, small, extremes, or close to the
			// saturation point for the known factor
			case ($urandom_range(0, 9))
				0, 1, 2, 3: coef = DATA_WIDTH'($urandom_range(0, WORD_MAX));
				4, 5:       coef = DATA_WIDTH'($urandom_range(0, 255));
				6: begin
					case ($urandom_range(0, 2))
						0:       coef = '0;
						1:       coef = DATA_WIDTH'(1);
						default: coef = DATA_WIDTH'(WORD_MAX);
					endcase
				end
				default: begin
					boundary = WORD_MAX / root + $urandom_range(0, 2);
					coef     = DATA_WIDTH'(boundary > 0 ?
						(boundary - 1 > WORD_MAX ? WORD_MAX : boundary - 1) : 0);
				end
			endcase
			send_request(coef, radicand);
		end

		// Let the last request land in the checker, then drain the results
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (results_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/radsimp_pkg.sv
rtl/core/radical_simplifier_top.sv
tb/radical_simplifier_checker.sv
tb/radical_simplifier_top_tb.sv
